>>> sv/trimmed_mean_sliding_window_filter_macros.svh
// Assertion macros shared by the filter's modules.
`ifndef TRIMMED_MEAN_SLIDING_WINDOW_FILTER_MACROS_SVH
`define TRIMMED_MEAN_SLIDING_WINDOW_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TMSWF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmswf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TMSWF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmswf: next-cycle check failed");

`endif

>>> sv/tmswf_pkg.sv
// Shared types and constants of the trimmed-mean sliding-window filter.
package tmswf_pkg;

    localparam int NUM_CH      = 10;
    localparam int SMP_W       = 32;
    localparam int TRIM_COUNT  = 2;
    localparam int CH_W        = 4;
    localparam int DATA_W      = NUM_CH * SMP_W;
    localparam int USER_W      = 1;
    localparam int MUL_CHUNK_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_SCAN,
        ST_LAST,
        ST_PREP,
        ST_DIV,
        ST_STORE,
        ST_OUT
    } tmswf_state_t;

    typedef struct packed {
        logic            capture;
        logic            mem_we;
        logic            rd_en;
        logic            acc_first;
        logic            div_load;
        logic            div_step;
        logic            store;
        logic            load_out;
        logic            full;
        logic [CH_W-1:0] ch;
    } tmswf_cmd_t;

    typedef struct packed {
        logic out_free;
    } tmswf_stat_t;

endpackage

>>> sv/tmswf_ctrl.sv
// Controller: sequences capture, window writes, scans, divides and output load.
`include "trimmed_mean_sliding_window_filter_macros.svh"

module tmswf_ctrl #(
    parameter int WINDOW = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  tmswf_pkg::tmswf_stat_t                status,
    output tmswf_pkg::tmswf_cmd_t                 cmd,
    output logic [$clog2(WINDOW)-1:0]             wr_slot,
    output logic [$clog2(WINDOW)-1:0]             rd_slot
);
    import tmswf_pkg::*;

    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int SUM_W     = SMP_W + $clog2(WINDOW);
    localparam int MUL_STEPS = (SUM_W + 1 + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
    localparam int STEP_W    = $clog2(MUL_STEPS + 1);

    tmswf_state_t      state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [SLOT_W-1:0] k_reg, k_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              full_reg, full_next;
    logic              full_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            k_reg     <= '0;
            step_reg  <= '0;
            slot_reg  <= '0;
            fill_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            slot_reg  <= slot_next;
            fill_reg  <= fill_next;
            full_reg  <= full_next;
        end
    end

    // The incoming word completes the window once WINDOW-1 are already held.
    assign full_now = (fill_reg >= FILL_W'(WINDOW - 1));

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        full_next  = full_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.ch     = ch_reg;
        cmd.full   = full_reg;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    full_next   = full_now;
                    ch_next     = '0;
                    k_next      = '0;
                    state_next  = full_now ? ST_SCAN : ST_PASS;
                end
            end
            ST_PASS:
            begin
                // window not yet full: store each channel, pass input through
                cmd.mem_we = 1'b1;
                if (ch_reg == CH_W'(NUM_CH - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en     = 1'b1;
                cmd.acc_first = (k_reg == '0);
                cmd.mem_we    = (k_reg == '0);
                if (k_reg == SLOT_W'(WINDOW - 1))
                begin
                    k_next     = '0;
                    state_next = ST_LAST;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                // one reciprocal chunk per cycle
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (ch_reg == CH_W'(NUM_CH - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    slot_next    = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                    if (fill_reg < FILL_W'(WINDOW))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign wr_slot = slot_reg;
    assign rd_slot = k_reg;

    `TMSWF_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_W'(WINDOW))
    `TMSWF_ASSERT_NOW(a_scan_needs_full, clk, rst_n, state_reg == ST_SCAN, full_reg)
    `TMSWF_ASSERT_NEXT(a_prep_to_div, clk, rst_n, state_reg == ST_PREP,
        state_reg == ST_DIV && step_reg == '0)

endmodule

>>> sv/tmswf_dp.sv
// Datapath: sample registers, window memory, min/max/sum scan, divider, output register.
`include "trimmed_mean_sliding_window_filter_macros.svh"

module tmswf_dp #(
    parameter int WINDOW = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tmswf_pkg::tmswf_cmd_t                 cmd,
    input  logic [$clog2(WINDOW)-1:0]             wr_slot,
    input  logic [$clog2(WINDOW)-1:0]             rd_slot,
    input  logic [tmswf_pkg::DATA_W-1:0]          s_tdata,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [tmswf_pkg::DATA_W-1:0]          m_tdata,
    output logic [tmswf_pkg::USER_W-1:0]          m_tuser,
    output tmswf_pkg::tmswf_stat_t                status
);
    import tmswf_pkg::*;

    localparam int ADDR_W    = $clog2(NUM_CH * WINDOW);
    localparam int SUM_W     = SMP_W + $clog2(WINDOW);
    localparam int RCP_W     = SUM_W + 1;
    localparam int MUL_STEPS = (RCP_W + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
    localparam int RCP_REG_W = MUL_STEPS * MUL_CHUNK_W;
    localparam int DIVISOR   = WINDOW - TRIM_COUNT;
    localparam int RCP_SH    = SUM_W + $clog2(DIVISOR);
    localparam int FINAL_SH  = RCP_SH - MUL_CHUNK_W * (MUL_STEPS - 1);
    localparam int PROD_W    = SUM_W + MUL_CHUNK_W;
    localparam int ACC_W     = PROD_W + 1;
    // ceil(2^RCP_SH / DIVISOR): exact quotient for every magnitude below 2^SUM_W
    localparam logic [RCP_REG_W-1:0] RECIP = RCP_REG_W'(
        ((64'd1 << RCP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic signed [SMP_W-1:0] smp_reg [NUM_CH];
    logic [SMP_W-1:0]        mem [NUM_CH * WINDOW];
    logic signed [SMP_W-1:0] rd_data_reg;
    logic                    rd_valid_reg;
    logic                    first_reg;
    logic                    sel_new_reg;
    logic signed [SMP_W-1:0] lo_reg, hi_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic [RCP_REG_W-1:0]    rcp_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic                    neg_reg;
    logic [DATA_W-1:0]       out_data_reg;
    logic                    out_full_reg;
    logic                    m_tvalid_reg;

    logic [ADDR_W-1:0]       waddr, raddr;
    logic signed [SMP_W-1:0] cur_smp;
    logic signed [SMP_W-1:0] acc_val;
    logic signed [SUM_W:0]   diff;
    logic [SUM_W:0]          diff_abs;
    logic [PROD_W-1:0]       prod;
    logic signed [SMP_W-1:0] q32;
    logic signed [SMP_W-1:0] res;
    logic [DATA_W-1:0]       pack;

    assign waddr   = ADDR_W'(cmd.ch) * ADDR_W'(WINDOW) + ADDR_W'(wr_slot);
    assign raddr   = ADDR_W'(cmd.ch) * ADDR_W'(WINDOW) + ADDR_W'(rd_slot);
    assign cur_smp = smp_reg[cmd.ch];

    // window memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[waddr] <= cur_smp;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // the slot written this item reads as the new sample
    assign acc_val = sel_new_reg ? cur_smp : rd_data_reg;

    assign diff     = (SUM_W + 1)'(sum_reg) - (SUM_W + 1)'(lo_reg) - (SUM_W + 1)'(hi_reg);
    assign diff_abs = diff[SUM_W] ? -diff : diff;

    // multiply the magnitude by one reciprocal chunk per cycle, lowest chunk first
    assign prod = PROD_W'(mag_reg) * PROD_W'(rcp_reg[MUL_CHUNK_W-1:0]);

    assign q32 = acc_reg[FINAL_SH +: SMP_W];
    assign res = neg_reg ? -q32 : q32;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            pack[c*SMP_W +: SMP_W] = smp_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg   <= cmd.acc_first;
        sel_new_reg <= (rd_slot == wr_slot);

        if (cmd.capture)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                smp_reg[c] <= s_tdata[c*SMP_W +: SMP_W];
            end
        end
        else if (cmd.store)
        begin
            smp_reg[cmd.ch] <= res;
        end

        if (rd_valid_reg)
        begin
            if (first_reg)
            begin
                lo_reg  <= acc_val;
                hi_reg  <= acc_val;
                sum_reg <= SUM_W'(acc_val);
            end
            else
            begin
                if (acc_val < lo_reg)
                begin
                    lo_reg <= acc_val;
                end
                if (acc_val > hi_reg)
                begin
                    hi_reg <= acc_val;
                end
                sum_reg <= sum_reg + SUM_W'(acc_val);
            end
        end

        if (cmd.div_load)
        begin
            neg_reg <= diff[SUM_W];
            mag_reg <= diff_abs[SUM_W-1:0];
            rcp_reg <= RECIP;
            acc_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            // drop the low chunk already settled, add the next partial product
            acc_reg <= (acc_reg >> MUL_CHUNK_W) + ACC_W'(prod);
            rcp_reg <= rcp_reg >> MUL_CHUNK_W;
        end

        if (cmd.load_out)
        begin
            out_data_reg <= pack;
            out_full_reg <= cmd.full;
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tuser         = USER_W'(out_full_reg);
    assign status.out_free = !m_tvalid_reg || m_tready;

    `TMSWF_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.load_out, !m_tvalid_reg || m_tready)
    `TMSWF_ASSERT_NEXT(a_lo_le_hi, clk, rst_n, rd_valid_reg, lo_reg <= hi_reg)
    `TMSWF_ASSERT_NOW(a_mean_bounds, clk, rst_n, cmd.store, res >= lo_reg && res <= hi_reg)

endmodule

>>> sv/trimmed_mean_sliding_window_filter.sv
// A word whose window is not yet full is stored channel by channel and leaves unchanged.
// A filtered word leaves once all ten channels have been worked in turn, each through
// a WINDOW-read memory scan, drain, load, a 3-step reciprocal multiply and store.
// Throughput: one word at a time; the next word is taken the cycle after a result loads.
// Reset (rst_n low, asynchronous): fill count and slot clear, window contents are
// not cleared since filtering begins only once every slot has been written.
module trimmed_mean_sliding_window_filter #(
    parameter int WINDOW = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata, from bit 0 up: in_pos_x, in_pos_y, in_pos_z, in_yaw,
    // in_lin_vel_x, in_lin_vel_y, in_lin_vel_z, in_ang_vel_x, in_ang_vel_y, in_ang_vel_z
    input  logic [tmswf_pkg::DATA_W-1:0]          s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata, from bit 0 up: out_pos_x, out_pos_y, out_pos_z, out_yaw,
    // out_lin_vel_x, out_lin_vel_y, out_lin_vel_z, out_ang_vel_x, out_ang_vel_y, out_ang_vel_z
    output logic [tmswf_pkg::DATA_W-1:0]          m_tdata,
    // m_tuser: window_full
    output logic [tmswf_pkg::USER_W-1:0]          m_tuser
);
    import tmswf_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);

    tmswf_cmd_t        cmd;
    tmswf_stat_t       status;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;

    // Controller: walks each channel through write, scan, divide and store, or only write
    // while the window is not yet full, then hands the finished word to the output register.
    tmswf_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .wr_slot  (wr_slot),
        .rd_slot  (rd_slot)
    );

    // Datapath: holds the samples, the per-channel rings, the trimmed-mean
    // arithmetic and the output register that decouples the two sides.
    tmswf_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr_slot  (wr_slot),
        .rd_slot  (rd_slot),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .status   (status)
    );

endmodule

>>> test/testbench.sv
// Testbench for the trimmed-mean sliding-window filter: prediction and scoreboard.
module testbench;

    import tmswf_pkg::*;

    localparam int WINDOW         = 8;
    localparam int HALF_PERIOD    = 5;
    localparam int RANDOM_WORDS   = 870;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 500;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;

    trimmed_mean_sliding_window_filter #(
        .WINDOW(WINDOW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    string chan_name [NUM_CH] = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_yaw",
                                  "out_lin_vel_x", "out_lin_vel_y", "out_lin_vel_z",
                                  "out_ang_vel_x", "out_ang_vel_y", "out_ang_vel_z"};

    // Predictor state: one ring of samples per channel, fill level and next slot.
    logic signed [SMP_W-1:0] ring_hist [NUM_CH][WINDOW];
    int                      ring_fill;
    int                      ring_slot;

    // Expected result words, {window_full, channels}, oldest first.
    logic [DATA_W:0] filtered_words [$];

    logic [DATA_W-1:0] last_word;
    int                burst_left;
    int                fail_count;
    int                stall_cycles;
    bit                hold_req;

    initial clk = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [SMP_W-1:0] corner_value(input int k);
        case (k % 7)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'h5555_5555;
            default: return 32'hAAAA_AAAA;
        endcase
    endfunction

    // Drop one minimum and one maximum, average the rest, truncate toward zero.
    function automatic logic signed [SMP_W-1:0] trim_mean(input int c);
        logic signed [SMP_W-1:0] lo;
        logic signed [SMP_W-1:0] hi;
        longint                  acc;
        lo  = ring_hist[c][0];
        hi  = ring_hist[c][0];
        acc = 0;
        for (int i = 0; i < WINDOW; i++) begin
            if (ring_hist[c][i] < lo)
                lo = ring_hist[c][i];
            if (ring_hist[c][i] > hi)
                hi = ring_hist[c][i];
            acc += longint'(ring_hist[c][i]);
        end
        if (lo == hi)
            return lo;
        acc = acc - longint'(lo) - longint'(hi);
        return SMP_W'(acc / longint'(WINDOW - TRIM_COUNT));
    endfunction

    // Advance the predictor by one accepted word and return the result it causes.
    function automatic logic [DATA_W:0] filter_word(input logic [DATA_W-1:0] w);
        logic [DATA_W:0] res;
        logic            full;
        for (int c = 0; c < NUM_CH; c++)
            ring_hist[c][ring_slot] = w[c*SMP_W +: SMP_W];
        ring_slot = (ring_slot + 1) % WINDOW;
        if (ring_fill < WINDOW)
            ring_fill++;
        full = (ring_fill >= WINDOW);
        for (int c = 0; c < NUM_CH; c++)
            res[c*SMP_W +: SMP_W] = full ? trim_mean(c) : w[c*SMP_W +: SMP_W];
        res[DATA_W] = full;
        return res;
    endfunction

    // Offer one word in bursts with random gaps; record its prediction on acceptance.
    // Enter and leave at a falling edge.
    task automatic send_word(input logic [DATA_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        filtered_words.insert(filtered_words.size(), filter_word(w));
        last_word = w;
        burst_left--;
        @(negedge clk);
    endtask

    // Pause the sender until every predicted word has been seen.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (filtered_words.size() != 0)
            @(negedge clk);
    endtask

    // Pass-through phase: every channel sees every corner value before the ring fills.
    task automatic test_fill_pass_through;
        logic [DATA_W-1:0] w;
        for (int k = 0; k < WINDOW - 1; k++) begin
            for (int c = 0; c < NUM_CH; c++)
                w[c*SMP_W +: SMP_W] = corner_value(k + c);
            send_word(w);
        end
    endtask

    // Fill each ring with one constant so that minimum equals maximum.
    task automatic test_flat_window;
        logic [DATA_W-1:0] w;
        for (int c = 0; c < NUM_CH; c++)
            w[c*SMP_W +: SMP_W] = corner_value(c * 3);
        repeat (WINDOW) send_word(w);
    endtask

    // Mix full-scale positive and negative samples: tied extremes, sums past 32 bits.
    task automatic test_wide_spread;
        logic [DATA_W-1:0] w;
        for (int k = 0; k < WINDOW; k++) begin
            for (int c = 0; c < NUM_CH; c++)
                w[c*SMP_W +: SMP_W] = ((k + c) % (c % 3 + 2) == 0) ? 32'h7FFF_FFFF
                                                                   : 32'h8000_0000;
            send_word(w);
        end
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure;
        logic [DATA_W-1:0] w;
        hold_req = 1'b1;
        repeat (5) begin
            for (int c = 0; c < NUM_CH; c++)
                w[c*SMP_W +: SMP_W] = $urandom;
            send_word(w);
        end
        drain();
    endtask

    // Random sample per channel: full range, drift, corners or a repeat of the last one.
    function automatic logic [SMP_W-1:0] next_sample(input logic [SMP_W-1:0] prev);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return prev + SMP_W'($urandom_range(0, 2047)) - 32'd1024;
            7:          return corner_value($urandom_range(0, 6));
            default:    return prev;
        endcase
    endfunction

    task automatic test_random;
        logic [DATA_W-1:0] w;
        int                steady_left;
        steady_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (steady_left > 0)
                steady_left--;
            else begin
                for (int c = 0; c < NUM_CH; c++)
                    w[c*SMP_W +: SMP_W] = next_sample(last_word[c*SMP_W +: SMP_W]);
                // Repeat one word long enough to flatten every ring now and then.
                if ($urandom_range(0, 19) == 0)
                    steady_left = WINDOW + $urandom_range(0, 4);
            end
            send_word(w);
            if ($urandom_range(0, 149) == 0)
                drain();
        end
    endtask

    // Receiver: stall on changing patterns, with stretches of constant readiness.
    initial begin
        int         mode;
        int         phase_left;
        int         hold_left;
        logic [7:0] mask;
        logic       rdy;
        m_tready   = 1'b0;
        mode       = 0;
        phase_left = 0;
        hold_left  = 0;
        mask       = 8'h01;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 600);
                mask       = $urandom_range(0, 255) | 8'h01;
            end
            phase_left--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = $urandom_range(0, 1);
                    2:       begin
                                 rdy  = mask[0];
                                 mask = {mask[0], mask[7:1]};
                             end
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_tready <= rdy;
        end
    end

    // Compare each result word with the oldest prediction, field by field.
    always @(posedge clk) begin
        logic [DATA_W:0] want;
        if (rst_n && m_tvalid && m_tready) begin
            if (filtered_words.size() == 0) begin
                $error("result word with no prediction waiting");
                fail_count++;
            end else begin
                want = filtered_words.pop_front();
                for (int c = 0; c < NUM_CH; c++) begin
                    if (m_tdata[c*SMP_W +: SMP_W] !== want[c*SMP_W +: SMP_W]) begin
                        $error("%s: expected %0d, actual %0d", chan_name[c],
                               $signed(want[c*SMP_W +: SMP_W]),
                               $signed(m_tdata[c*SMP_W +: SMP_W]));
                        fail_count++;
                    end
                end
                if (m_tuser[0] !== want[DATA_W]) begin
                    $error("window_full: expected %0d, actual %0d", want[DATA_W], m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when neither side has moved a word for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        last_word  = '0;
        burst_left = 0;
        fail_count = 0;
        hold_req   = 1'b0;
        ring_fill  = 0;
        ring_slot  = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_fill_pass_through();
        test_flat_window();
        test_wide_spread();
        test_backpressure();
        test_random();

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (filtered_words.size() != 0) begin
            $error("%0d predicted words never arrived", filtered_words.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
